// File: hw/rtl/lppod_pkg.sv
// Shared constants and types for the long-press power-off debouncer.
package lppod_pkg;

   localparam int unsigned TimerWidth = 8;
   localparam int unsigned AgeWidth   = 16;
   localparam int unsigned CsrWidth   = 16;
   localparam int unsigned CsrIdxWidth = 2;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SENSING_ENABLED  = 2'd0,
      CSR_SAMPLE_PERIOD_MS = 2'd1,
      CSR_STABLE_MS        = 2'd2,
      CSR_HOLD_MS          = 2'd3
   } csr_index_type;

   localparam logic [TimerWidth-1:0] SamplePeriodReset = 8'd50;
   localparam logic [AgeWidth-1:0]   StableReset       = 16'd100;
   localparam logic [AgeWidth-1:0]   HoldReset         = 16'd4000;

   typedef struct packed {
      logic debounced_pressed;
      logic level_changed;
      logic release_prompt;
      logic awaiting_release;
      logic power_off;
   } result_type;

endpackage

// File: hw/rtl/long_press_power_off_debouncer.sv
// Long-press power-off detector: debounces a button sampled on millisecond ticks.
//
// Each request is one millisecond tick carrying the raw button level. With sensing
// enabled, the level is sampled every sample_period_ms ticks; a sampled level is
// taken as the debounced level once it has stayed unchanged for stable_ms. After a
// stable release the detector arms; an armed press held for hold_ms raises
// awaiting_release (with a one-tick release_prompt), and the release that follows
// sets power_off, which stays set until reset. Elapsed-time counters saturate at
// 65535 ms. Throughput is one request per clock unless rsp_stall holds a full result
// register. A request is held in the input register, then passes through the single
// state-update step into the result register, which drives rsp_*. Configuration
// writes take effect on the next clock and belong in idle periods only.
module long_press_power_off_debouncer (
   input  logic                                     clock,
   input  logic                                     reset,
   // configuration write port
   input  logic                                     csr_write_enable,
   input  logic [lppod_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [lppod_pkg::CsrWidth-1:0]           csr_wdata,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_raw_pressed,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_debounced_pressed,
   output logic                                     rsp_level_changed,
   output logic                                     rsp_release_prompt,
   output logic                                     rsp_awaiting_release,
   output logic                                     rsp_power_off
);

   localparam int unsigned TW = lppod_pkg::TimerWidth;
   localparam int unsigned AW = lppod_pkg::AgeWidth;

   // configuration registers
   logic          sensing_enabled_ff;
   logic [TW-1:0] sample_period_ff;
   logic [AW-1:0] stable_ms_ff;
   logic [AW-1:0] hold_ms_ff;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_raw_ff,   in_raw_in;

   // detector state
   logic [TW-1:0] sample_timer_ff,   sample_timer_in;
   logic          candidate_ff,      candidate_in;
   logic          accepted_ff,       accepted_in;
   logic          armed_ff,          armed_in;
   logic          wait_release_ff,   wait_release_in;
   logic [AW-1:0] change_age_ff,     change_age_in;
   logic [AW-1:0] press_age_ff,      press_age_in;
   logic          off_ff,            off_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   lppod_pkg::result_type rsp_data_ff,  rsp_data_in;

   logic advance;
   logic req_take;

   // Move the held request into the result register when that register is
   // empty or being drained this cycle.
   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = req_take | (in_valid_ff & ~advance);
      in_raw_in   = req_take ? req_raw_pressed : in_raw_ff;
   end

   // State update for one tick.
   logic [TW-1:0] timer_inc;
   logic [AW-1:0] change_inc;
   logic [AW-1:0] press_inc;
   logic          sample;
   logic          cand_flip;
   logic [AW-1:0] change_after;
   logic          stable_ok;
   logic          armed_next;
   logic          acc_flip;
   logic [AW-1:0] press_after;
   logic          prompt;
   logic          wait_next;

   always_comb begin
      // advance all timers first, saturating
      timer_inc  = (&sample_timer_ff) ? sample_timer_ff : sample_timer_ff + TW'(1);
      change_inc = (&change_age_ff)   ? change_age_ff   : change_age_ff + AW'(1);
      press_inc  = (&press_age_ff)    ? press_age_ff    : press_age_ff + AW'(1);

      sample       = sensing_enabled_ff & (timer_inc >= sample_period_ff);
      cand_flip    = in_raw_ff != candidate_ff;
      change_after = cand_flip ? '0 : change_inc;
      stable_ok    = change_after >= stable_ms_ff;

      // arm on a stable release, then take the candidate as the debounced level
      armed_next  = armed_ff | ~in_raw_ff;
      acc_flip    = in_raw_ff != accepted_ff;
      press_after = acc_flip ? '0 : press_inc;
      prompt      = armed_next & in_raw_ff & ~wait_release_ff & (press_after >= hold_ms_ff);
      wait_next   = wait_release_ff | prompt;

      sample_timer_in = timer_inc;
      candidate_in    = candidate_ff;
      change_age_in   = change_inc;
      accepted_in     = accepted_ff;
      press_age_in    = press_inc;
      armed_in        = armed_ff;
      wait_release_in = wait_release_ff;
      off_in          = off_ff;

      rsp_data_in.level_changed  = 1'b0;
      rsp_data_in.release_prompt = 1'b0;

      if (sample) begin
         sample_timer_in = '0;
         candidate_in    = in_raw_ff;
         change_age_in   = change_after;
         if (stable_ok) begin
            armed_in        = armed_next;
            accepted_in     = in_raw_ff;
            press_age_in    = press_after;
            wait_release_in = wait_next;
            off_in          = off_ff | (wait_next & ~in_raw_ff);
            rsp_data_in.level_changed  = acc_flip;
            rsp_data_in.release_prompt = prompt;
         end
      end

      rsp_data_in.debounced_pressed = accepted_in;
      rsp_data_in.awaiting_release  = wait_release_in;
      rsp_data_in.power_off         = off_in;

      rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensing_enabled_ff <= 1'b0;
         sample_period_ff   <= lppod_pkg::SamplePeriodReset;
         stable_ms_ff       <= lppod_pkg::StableReset;
         hold_ms_ff         <= lppod_pkg::HoldReset;
      end else if (csr_write_enable) begin
         case (lppod_pkg::csr_index_type'(csr_index))
            lppod_pkg::CSR_SENSING_ENABLED:  sensing_enabled_ff <= csr_wdata[0];
            lppod_pkg::CSR_SAMPLE_PERIOD_MS: sample_period_ff   <= csr_wdata[TW-1:0];
            lppod_pkg::CSR_STABLE_MS:        stable_ms_ff       <= csr_wdata[AW-1:0];
            lppod_pkg::CSR_HOLD_MS:          hold_ms_ff         <= csr_wdata[AW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         sample_timer_ff <= '0;
         candidate_ff    <= 1'b0;
         accepted_ff     <= 1'b0;
         armed_ff        <= 1'b0;
         wait_release_ff <= 1'b0;
         change_age_ff   <= '0;
         press_age_ff    <= '0;
         off_ff          <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // commit detector state only when a tick moves to the result register
         if (advance) begin
            sample_timer_ff <= sample_timer_in;
            candidate_ff    <= candidate_in;
            accepted_ff     <= accepted_in;
            armed_ff        <= armed_in;
            wait_release_ff <= wait_release_in;
            change_age_ff   <= change_age_in;
            press_age_ff    <= press_age_in;
            off_ff          <= off_in;
         end
      end
   end

   // payload registers: hold while stalled
   always_ff @(posedge clock) begin
      in_raw_ff <= in_raw_in;
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_debounced_pressed = rsp_data_ff.debounced_pressed;
   assign rsp_level_changed     = rsp_data_ff.level_changed;
   assign rsp_release_prompt    = rsp_data_ff.release_prompt;
   assign rsp_awaiting_release  = rsp_data_ff.awaiting_release;
   assign rsp_power_off         = rsp_data_ff.power_off;

endmodule
